// ===== rtl/aff_pkg.sv =====
// Shared types and constants for the aging FIFO with next-hop lookup.
`timescale 1ns / 1ps

package aff_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 7;
    localparam int OP_W   = 3;

    localparam logic [OP_W-1:0] OP_ENQ   = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ   = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd2;
    localparam logic [OP_W-1:0] OP_TAKE  = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

    localparam logic CFG_SIZE_LIMIT = 1'b0;
    localparam logic CFG_MAX_AGE    = 1'b1;

    localparam logic [CNT_W-1:0]  LIMIT_RESET = 7'd64;
    localparam logic [WORD_W-1:0] AGE_RESET   = 32'd1000;

    typedef enum logic [2:0] {
        KIND_ENQ,
        KIND_DEQ,
        KIND_FIND,
        KIND_TAKE,
        KIND_FLUSH,
        KIND_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [WORD_W-1:0] now;
        logic [WORD_W-1:0] hop;
        logic [WORD_W-1:0] tag;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

// ===== rtl/aff_front.sv =====
// Front end: accepts input words, classifies the op and queues commands.
`timescale 1ns / 1ps

module aff_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [aff_pkg::OP_W-1:0] s_op,
    input  logic [aff_pkg::WORD_W-1:0] s_now,
    input  logic [aff_pkg::WORD_W-1:0] s_next_hop,
    input  logic [aff_pkg::WORD_W-1:0] s_entry_tag,
    output logic                     cmd_valid,
    output aff_pkg::cmd_t            cmd,
    input  logic                     cmd_pop
);

    aff_pkg::cmd_t     slot_reg [2];
    logic              wp_reg, wp_next;
    logic              rp_reg, rp_next;
    logic [1:0]        fill_reg, fill_next;
    aff_pkg::cmd_kind_t kind;
    logic              push;

    always_comb begin
        case (s_op)
            aff_pkg::OP_ENQ:   kind = aff_pkg::KIND_ENQ;
            aff_pkg::OP_DEQ:   kind = aff_pkg::KIND_DEQ;
            aff_pkg::OP_FIND:  kind = aff_pkg::KIND_FIND;
            aff_pkg::OP_TAKE:  kind = aff_pkg::KIND_TAKE;
            aff_pkg::OP_FLUSH: kind = aff_pkg::KIND_FLUSH;
            default:           kind = aff_pkg::KIND_BAD;
        endcase
    end

    assign s_ready   = (fill_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rp_reg];

    always_comb begin
        wp_next   = push ? ~wp_reg : wp_reg;
        rp_next   = cmd_pop ? ~rp_reg : rp_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= '{kind: kind, now: s_now, hop: s_next_hop, tag: s_entry_tag};
        end
    end

endmodule

// ===== rtl/aff_engine.sv =====
// Back end: entry memory, purge/compaction walk, config registers and result register.
`timescale 1ns / 1ps

module aff_engine #(
    parameter int DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_idx,
    input  logic [aff_pkg::WORD_W-1:0]   cfg_wdata,
    input  logic                         cmd_valid,
    input  aff_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [aff_pkg::WORD_W-1:0]   m_out_next_hop,
    output logic [aff_pkg::WORD_W-1:0]   m_out_tag,
    output logic [aff_pkg::WORD_W-1:0]   m_out_time,
    output logic [aff_pkg::CNT_W-1:0]    m_count,
    output logic [aff_pkg::CNT_W-1:0]    m_purged
);

    localparam int AW    = $clog2(DEPTH);
    localparam int W     = aff_pkg::WORD_W;
    localparam int CW    = aff_pkg::CNT_W;
    localparam int ENT_W = 3 * W;

    // entry layout: {time, tag, hop}
    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rdata_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;

    aff_pkg::state_t    state_reg, state_next;
    aff_pkg::cmd_kind_t kind_reg, kind_next;
    logic [W-1:0]  now_reg, now_next;
    logic [W-1:0]  hop_reg, hop_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [W-1:0]  age_reg, age_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [CW-1:0] drop_reg, drop_next;
    logic          vld_reg, vld_next;
    logic          found_reg, found_next;
    logic [W-1:0]  chop_reg, chop_next;
    logic [W-1:0]  ctag_reg, ctag_next;
    logic [W-1:0]  ctime_reg, ctime_next;

    logic          m_valid_reg, m_valid_next;
    logic          m_ok_reg, m_ok_next;
    logic [W-1:0]  m_hop_reg, m_hop_next;
    logic [W-1:0]  m_tag_reg, m_tag_next;
    logic [W-1:0]  m_time_reg, m_time_next;
    logic [CW-1:0] m_cnt_reg, m_cnt_next;
    logic [CW-1:0] m_drop_reg, m_drop_next;

    logic          out_free;
    logic          is_walk;
    logic          scan_done;
    logic [W-1:0]  r_hop, r_tag, r_time;
    logic          expired;

    assign out_free  = !m_valid_reg || m_ready;
    assign is_walk   = (cmd.kind == aff_pkg::KIND_DEQ) || (cmd.kind == aff_pkg::KIND_FIND)
                    || (cmd.kind == aff_pkg::KIND_TAKE);
    assign scan_done = (rd_reg == cnt_reg) && !vld_reg;
    assign r_hop     = rdata_reg[W-1:0];
    assign r_tag     = rdata_reg[2*W-1:W];
    assign r_time    = rdata_reg[3*W-1:2*W];
    // deadline formed in 33 bits so it never wraps
    assign expired   = ({1'b0, r_time} + {1'b0, age_reg}) <= {1'b0, now_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            aff_pkg::ST_IDLE: begin
                if (cmd_valid && out_free && is_walk) begin
                    state_next = aff_pkg::ST_SCAN;
                end
            end
            aff_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = aff_pkg::ST_IDLE;
                end
            end
            default: state_next = aff_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        kind_next    = kind_reg;
        now_next     = now_reg;
        hop_next     = hop_reg;
        cnt_next     = cnt_reg;
        limit_next   = limit_reg;
        age_next     = age_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        drop_next    = drop_reg;
        vld_next     = 1'b0;
        found_next   = found_reg;
        chop_next    = chop_reg;
        ctag_next    = ctag_reg;
        ctime_next   = ctime_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_ok_next    = m_ok_reg;
        m_hop_next   = m_hop_reg;
        m_tag_next   = m_tag_reg;
        m_time_next  = m_time_reg;
        m_cnt_next   = m_cnt_reg;
        m_drop_next  = m_drop_reg;
        cmd_pop      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = AW'(cnt_reg);
        mem_wdata    = {cmd.now, cmd.tag, cmd.hop};
        mem_raddr    = AW'(rd_reg);

        if (cfg_we) begin
            if (cfg_idx == aff_pkg::CFG_SIZE_LIMIT) begin
                limit_next = cfg_wdata[CW-1:0];
            end else begin
                age_next = cfg_wdata;
            end
        end

        case (state_reg)
            aff_pkg::ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop      = 1'b1;
                    m_ok_next    = 1'b0;
                    m_hop_next   = '0;
                    m_tag_next   = '0;
                    m_time_next  = '0;
                    m_drop_next  = '0;
                    m_cnt_next   = cnt_reg;
                    m_valid_next = !is_walk;
                    case (cmd.kind)
                        aff_pkg::KIND_ENQ: begin
                            if (cnt_reg < limit_reg && 32'(cnt_reg) < DEPTH) begin
                                mem_we     = 1'b1;
                                cnt_next   = cnt_reg + 1'b1;
                                m_cnt_next = cnt_reg + 1'b1;
                                m_ok_next  = 1'b1;
                            end
                        end
                        aff_pkg::KIND_FLUSH: begin
                            cnt_next   = '0;
                            m_cnt_next = '0;
                            m_ok_next  = 1'b1;
                        end
                        aff_pkg::KIND_DEQ, aff_pkg::KIND_FIND, aff_pkg::KIND_TAKE: begin
                            kind_next  = cmd.kind;
                            now_next   = cmd.now;
                            hop_next   = cmd.hop;
                            rd_next    = '0;
                            wr_next    = '0;
                            drop_next  = '0;
                            found_next = 1'b0;
                            chop_next  = '0;
                            ctag_next  = '0;
                            ctime_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            aff_pkg::ST_SCAN: begin
                if (rd_reg < cnt_reg) begin
                    rd_next  = rd_reg + 1'b1;
                    vld_next = 1'b1;
                end
                mem_waddr = AW'(wr_reg);
                mem_wdata = rdata_reg;
                if (vld_reg) begin
                    if (expired) begin
                        drop_next = drop_reg + 1'b1;
                    end else if (!found_reg && (kind_reg == aff_pkg::KIND_DEQ
                                 || r_hop == hop_reg)) begin
                        found_next = 1'b1;
                        if (kind_reg == aff_pkg::KIND_FIND) begin
                            mem_we  = 1'b1;
                            wr_next = wr_reg + 1'b1;
                        end else begin
                            // removed entry is captured and not written back
                            chop_next  = r_hop;
                            ctag_next  = r_tag;
                            ctime_next = r_time;
                        end
                    end else begin
                        mem_we  = 1'b1;
                        wr_next = wr_reg + 1'b1;
                    end
                end
                if (scan_done) begin
                    cnt_next     = wr_reg;
                    m_valid_next = 1'b1;
                    m_ok_next    = found_reg;
                    m_hop_next   = chop_reg;
                    m_tag_next   = ctag_reg;
                    m_time_next  = ctime_reg;
                    m_cnt_next   = wr_reg;
                    m_drop_next  = drop_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= aff_pkg::ST_IDLE;
            cnt_reg     <= '0;
            limit_reg   <= aff_pkg::LIMIT_RESET;
            age_reg     <= aff_pkg::AGE_RESET;
            vld_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            limit_reg   <= limit_next;
            age_reg     <= age_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        now_reg    <= now_next;
        hop_reg    <= hop_next;
        rd_reg     <= rd_next;
        wr_reg     <= wr_next;
        drop_reg   <= drop_next;
        found_reg  <= found_next;
        chop_reg   <= chop_next;
        ctag_reg   <= ctag_next;
        ctime_reg  <= ctime_next;
        m_ok_reg   <= m_ok_next;
        m_hop_reg  <= m_hop_next;
        m_tag_reg  <= m_tag_next;
        m_time_reg <= m_time_next;
        m_cnt_reg  <= m_cnt_next;
        m_drop_reg <= m_drop_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign m_valid        = m_valid_reg;
    assign m_ok           = m_ok_reg;
    assign m_out_next_hop = m_hop_reg;
    assign m_out_tag      = m_tag_reg;
    assign m_out_time     = m_time_reg;
    assign m_count        = m_cnt_reg;
    assign m_purged       = m_drop_reg;

endmodule

// ===== rtl/aging_fifo_with_key_extract_core.sv =====
// Top level of the aging FIFO with next-hop lookup.
`timescale 1ns / 1ps

// Usage:
//   s_* channel (valid/ready) carries one op word: enqueue, dequeue head, find
//   by next hop, take by next hop, flush. m_* channel returns one result word
//   per op: ok, removed entry, count after the op and entries purged.
//   cfg_we/cfg_idx/cfg_wdata write size_limit (index 0) and max_age (index 1);
//   write only while the block is idle.
// Flow:
//   A two-word command queue decouples input from the engine, so s_ready stays
//   high until two words are waiting. Each accepted word is registered in the
//   queue before it reaches the engine, which takes a new word only while idle
//   and its output register is free. Enqueue, flush and unknown ops are done in
//   the idle state. Dequeue, find and take walk the stored entries through
//   the single-port-read entry memory; purge and compaction happen in that
//   same walk.
// Reset: aresetn (synchronous, active low) empties the queue and restores
//   size_limit = 64, max_age = 1000. No memory clearing pass is needed.
// Stall: a held result sits in the output register; the engine waits for it
//   to drain before starting the next op, and the queue then fills and drops
//   s_ready.
module aging_fifo_with_key_extract_core #(
    parameter int DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_idx,
    input  logic [aff_pkg::WORD_W-1:0]   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [aff_pkg::OP_W-1:0]     s_op,
    input  logic [aff_pkg::WORD_W-1:0]   s_now,
    input  logic [aff_pkg::WORD_W-1:0]   s_next_hop,
    input  logic [aff_pkg::WORD_W-1:0]   s_entry_tag,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [aff_pkg::WORD_W-1:0]   m_out_next_hop,
    output logic [aff_pkg::WORD_W-1:0]   m_out_tag,
    output logic [aff_pkg::WORD_W-1:0]   m_out_time,
    output logic [aff_pkg::CNT_W-1:0]    m_count,
    output logic [aff_pkg::CNT_W-1:0]    m_purged
);

    logic          cmd_valid;
    logic          cmd_pop;
    aff_pkg::cmd_t cmd;

    aff_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_now      (s_now),
        .s_next_hop (s_next_hop),
        .s_entry_tag(s_entry_tag),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    aff_engine #(
        .DEPTH(DEPTH)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_out_next_hop(m_out_next_hop),
        .m_out_tag     (m_out_tag),
        .m_out_time    (m_out_time),
        .m_count       (m_count),
        .m_purged      (m_purged)
    );

endmodule

// ===== sim/aging_fifo_with_key_extract_core_tb.sv =====
// Self-checking testbench for the aging FIFO with next-hop lookup.
`timescale 1ns / 1ps

module aging_fifo_with_key_extract_core_tb;

    localparam int DEPTH = 64;

    typedef struct {
        logic                       ok;
        logic [aff_pkg::WORD_W-1:0] hop;
        logic [aff_pkg::WORD_W-1:0] tag;
        logic [aff_pkg::WORD_W-1:0] stamp;
        logic [aff_pkg::CNT_W-1:0]  cnt;
        logic [aff_pkg::CNT_W-1:0]  purged;
    } fifo_result_t;

    typedef struct {
        logic [aff_pkg::OP_W-1:0]   op;
        logic [aff_pkg::WORD_W-1:0] now;
        logic [aff_pkg::WORD_W-1:0] hop;
        logic [aff_pkg::WORD_W-1:0] tag;
        bit                         typed;
        fifo_result_t               res;
    } op_row_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_we;
    logic                       cfg_idx;
    logic [aff_pkg::WORD_W-1:0] cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic [aff_pkg::OP_W-1:0]   s_op;
    logic [aff_pkg::WORD_W-1:0] s_now;
    logic [aff_pkg::WORD_W-1:0] s_next_hop;
    logic [aff_pkg::WORD_W-1:0] s_entry_tag;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_ok;
    logic [aff_pkg::WORD_W-1:0] m_out_next_hop;
    logic [aff_pkg::WORD_W-1:0] m_out_tag;
    logic [aff_pkg::WORD_W-1:0] m_out_time;
    logic [aff_pkg::CNT_W-1:0]  m_count;
    logic [aff_pkg::CNT_W-1:0]  m_purged;

    aging_fifo_with_key_extract_core #(.DEPTH(DEPTH)) DUT (.*);

    // shadow queue state
    logic [aff_pkg::WORD_W-1:0] hop_q [DEPTH];
    logic [aff_pkg::WORD_W-1:0] tag_q [DEPTH];
    logic [aff_pkg::WORD_W-1:0] stamp_q [DEPTH];
    int unsigned                held;
    logic [aff_pkg::CNT_W-1:0]  size_limit;
    logic [aff_pkg::WORD_W-1:0] max_age;

    fifo_result_t pending_results[$];
    int errors;
    int words_in;
    int words_out;
    int send_idle_pct;
    int recv_idle_pct;
    logic [aff_pkg::WORD_W-1:0] clock_now;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Some tests failed");
        $finish;
    end

    function automatic void drop_at(int unsigned pos);
        for (int unsigned k = pos; k + 1 < held; k++) begin
            hop_q[k]   = hop_q[k+1];
            tag_q[k]   = tag_q[k+1];
            stamp_q[k] = stamp_q[k+1];
        end
        if (held > 0) held--;
    endfunction

    // drops every entry whose stamp + max_age (33 bits) is not after now
    function automatic int unsigned purge_expired(logic [aff_pkg::WORD_W-1:0] now);
        int unsigned wr;
        int unsigned gone;
        wr = 0;
        gone = 0;
        for (int unsigned rd = 0; rd < held; rd++) begin
            if ({1'b0, stamp_q[rd]} + {1'b0, max_age} > {1'b0, now}) begin
                hop_q[wr]   = hop_q[rd];
                tag_q[wr]   = tag_q[rd];
                stamp_q[wr] = stamp_q[rd];
                wr++;
            end else begin
                gone++;
            end
        end
        held = wr;
        return gone;
    endfunction

    function automatic fifo_result_t fifo_apply(logic [aff_pkg::OP_W-1:0] op,
                                                logic [aff_pkg::WORD_W-1:0] now,
                                                logic [aff_pkg::WORD_W-1:0] hop,
                                                logic [aff_pkg::WORD_W-1:0] tag);
        fifo_result_t r;
        int unsigned  lim;
        int           hit;
        r = '{ok: 1'b0, hop: '0, tag: '0, stamp: '0, cnt: '0, purged: '0};
        lim = (size_limit > DEPTH) ? DEPTH : size_limit;
        hit = -1;
        case (op)
            aff_pkg::OP_ENQ: begin
                if (held < lim) begin
                    hop_q[held]   = hop;
                    tag_q[held]   = tag;
                    stamp_q[held] = now;
                    held++;
                    r.ok = 1'b1;
                end
            end
            aff_pkg::OP_DEQ, aff_pkg::OP_FIND, aff_pkg::OP_TAKE: begin
                r.purged = purge_expired(now);
                if (op == aff_pkg::OP_DEQ) begin
                    if (held > 0) hit = 0;
                end else begin
                    for (int unsigned k = 0; k < held; k++)
                        if (hit < 0 && hop_q[k] == hop) hit = k;
                end
                if (hit >= 0) begin
                    r.ok = 1'b1;
                    if (op != aff_pkg::OP_FIND) begin
                        r.hop   = hop_q[hit];
                        r.tag   = tag_q[hit];
                        r.stamp = stamp_q[hit];
                        drop_at(hit);
                    end
                end
            end
            aff_pkg::OP_FLUSH: begin
                held = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.cnt = held[aff_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [aff_pkg::WORD_W-1:0] got,
                                   logic [aff_pkg::WORD_W-1:0] want);
        errors++;
        $display("%0t: result word %0d, %s is %h, expected %h", $realtime, words_out, field,
                 got, want);
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        fifo_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing outstanding", $realtime);
            end else begin
                want = pending_results.pop_front();
                if (m_ok !== want.ok) report_mismatch("ok", m_ok, want.ok);
                if (m_out_next_hop !== want.hop)
                    report_mismatch("next_hop", m_out_next_hop, want.hop);
                if (m_out_tag !== want.tag) report_mismatch("tag", m_out_tag, want.tag);
                if (m_out_time !== want.stamp) report_mismatch("time", m_out_time, want.stamp);
                if (m_count !== want.cnt) report_mismatch("count", m_count, want.cnt);
                if (m_purged !== want.purged) report_mismatch("purged", m_purged, want.purged);
            end
            words_out++;
        end
    end

    // entered and left just after a falling edge; valid stays up for back-to-back words
    task automatic send_word(op_row_t row);
        fifo_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_op        = row.op;
        s_now       = row.now;
        s_next_hop  = row.hop;
        s_entry_tag = row.tag;
        do @(posedge aclk); while (!s_ready);
        predicted = fifo_apply(row.op, row.now, row.hop, row.tag);
        if (row.typed) predicted = row.res;
        pending_results.insert(pending_results.size(), predicted);
        words_in++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DEPTH + 4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [aff_pkg::WORD_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = data;
        if (idx == aff_pkg::CFG_SIZE_LIMIT) size_limit = data[aff_pkg::CNT_W-1:0];
        else max_age = data;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function automatic fifo_result_t res(logic ok, logic [aff_pkg::WORD_W-1:0] hop,
                                         logic [aff_pkg::WORD_W-1:0] tag,
                                         logic [aff_pkg::WORD_W-1:0] stamp,
                                         logic [aff_pkg::CNT_W-1:0] cnt,
                                         logic [aff_pkg::CNT_W-1:0] purged);
        res = '{ok: ok, hop: hop, tag: tag, stamp: stamp, cnt: cnt, purged: purged};
    endfunction

    function automatic op_row_t row(logic [aff_pkg::OP_W-1:0] op,
                                    logic [aff_pkg::WORD_W-1:0] now,
                                    logic [aff_pkg::WORD_W-1:0] hop,
                                    logic [aff_pkg::WORD_W-1:0] tag,
                                    bit typed, fifo_result_t r);
        row = '{op: op, now: now, hop: hop, tag: tag, typed: typed, res: r};
    endfunction

    // random phase: enq_pct weights enqueue, step caps how far time moves per word
    task automatic run_random(int words, int enq_pct, int step);
        op_row_t     r;
        int unsigned pick;
        for (int n = 0; n < words; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < enq_pct) r.op = aff_pkg::OP_ENQ;
            else if (pick < enq_pct + (100 - enq_pct) * 3 / 10) r.op = aff_pkg::OP_TAKE;
            else if (pick < enq_pct + (100 - enq_pct) * 6 / 10) r.op = aff_pkg::OP_DEQ;
            else if (pick < 97) r.op = aff_pkg::OP_FIND;
            else if (pick < 98) r.op = aff_pkg::OP_FLUSH;
            else r.op = aff_pkg::OP_W'($urandom_range(5, 7));
            pick = $urandom_range(0, 99);
            if (pick < 2) clock_now = $urandom;                    // may step backwards
            else if (pick < 3) clock_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            else clock_now += $urandom_range(0, step);
            r.now   = clock_now;
            r.hop   = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 7) : $urandom;
            r.tag   = $urandom;
            r.typed = 1'b0;
            send_word(r);
            if ($urandom_range(0, 199) == 0) wait_idle();
        end
    endtask

    initial begin
        op_row_t      directed[$];
        fifo_result_t none;
        none          = res(1'b0, '0, '0, '0, '0, '0);
        errors        = 0;
        words_in      = 0;
        words_out     = 0;
        send_idle_pct = 8;
        recv_idle_pct = 45;
        clock_now     = 32'd2000;
        held          = 0;
        size_limit    = aff_pkg::LIMIT_RESET;
        max_age       = aff_pkg::AGE_RESET;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = aff_pkg::CFG_SIZE_LIMIT;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_op          = aff_pkg::OP_ENQ;
        s_now         = '0;
        s_next_hop    = '0;
        s_entry_tag   = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        directed = '{
            row(aff_pkg::OP_DEQ,   32'd0,  32'd0, 32'd0, 1, none),
            row(aff_pkg::OP_FIND,  32'd0,  32'd0, 32'd0, 1, none),
            row(aff_pkg::OP_TAKE,  32'd0,  32'd0, 32'd0, 1, none),
            row(aff_pkg::OP_ENQ,   32'd10, 32'hFFFF_FFFF, 32'd0, 1, res(1, 0, 0, 0, 1, 0)),
            row(aff_pkg::OP_ENQ,   32'd20, 32'd0, 32'hFFFF_FFFF, 1, res(1, 0, 0, 0, 2, 0)),
            row(aff_pkg::OP_ENQ,   32'd30, 32'd5, 32'd7, 1, res(1, 0, 0, 0, 3, 0)),
            row(aff_pkg::OP_FIND,  32'd40, 32'd0, 32'd0, 1, res(1, 0, 0, 0, 3, 0)),
            row(aff_pkg::OP_TAKE,  32'd50, 32'd0, 32'd0, 1,
                res(1, 32'd0, 32'hFFFF_FFFF, 32'd20, 2, 0)),
            row(aff_pkg::OP_DEQ,   32'd60, 32'd0, 32'd0, 1,
                res(1, 32'hFFFF_FFFF, 32'd0, 32'd10, 1, 0)),
            row(aff_pkg::OP_ENQ,   32'd1000, 32'd9, 32'h1234_5678, 1, res(1, 0, 0, 0, 2, 0)),
            // entry stamped 30 expires exactly at 1030
            row(aff_pkg::OP_DEQ,   32'd1030, 32'd0, 32'd0, 1,
                res(1, 32'd9, 32'h1234_5678, 32'd1000, 0, 1)),
            row(3'd5,              32'd1040, 32'd1, 32'd1, 1, none),
            row(3'd7,              32'd1040, 32'd1, 32'd1, 1, none),
            row(aff_pkg::OP_ENQ,   32'd1050, 32'd1, 32'd2, 0, none),
            row(aff_pkg::OP_ENQ,   32'd1060, 32'd1, 32'd3, 0, none),
            row(aff_pkg::OP_FLUSH, 32'd1070, 32'd0, 32'd0, 1, res(1, 0, 0, 0, 0, 0)),
            row(aff_pkg::OP_TAKE,  32'd1080, 32'd1, 32'd0, 1, none),
            // deadline past 2^32 must not wrap
            row(aff_pkg::OP_ENQ,   32'hFFFF_FFF0, 32'd3, 32'd4, 0, none),
            row(aff_pkg::OP_FIND,  32'hFFFF_FFFF, 32'd3, 32'd0, 0, none),
            row(aff_pkg::OP_TAKE,  32'hFFFF_FFFF, 32'd3, 32'd0, 0, none),
            row(aff_pkg::OP_ENQ,   32'd5, 32'd6, 32'd6, 0, none),
            row(aff_pkg::OP_DEQ,   32'd3000, 32'd0, 32'd0, 0, none),
            row(3'd6,              32'd3000, 32'd0, 32'd0, 0, none)
        };
        foreach (directed[i]) send_word(directed[i]);
        run_random(60, 45, 60);

        wait_idle();
        write_reg(aff_pkg::CFG_SIZE_LIMIT, 32'hFFFF_FF80);    // limit zero, upper bits ignored
        write_reg(aff_pkg::CFG_MAX_AGE, 32'd0);
        run_random(40, 50, 4);

        wait_idle();
        send_idle_pct = 45;
        recv_idle_pct = 8;
        write_reg(aff_pkg::CFG_SIZE_LIMIT, 32'd70);           // above depth
        write_reg(aff_pkg::CFG_MAX_AGE, 32'hFFFF_FFFF);
        run_random(150, 75, 100);

        wait_idle();
        write_reg(aff_pkg::CFG_SIZE_LIMIT, 32'd3);
        write_reg(aff_pkg::CFG_MAX_AGE, 32'd5);
        run_random(60, 55, 4);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(aff_pkg::CFG_SIZE_LIMIT, 32'd64);
        write_reg(aff_pkg::CFG_MAX_AGE, 32'd200);
        run_random(170, 50, 20);

        wait_idle();
        repeat (100) @(posedge aclk);
        $display("Sent %0d op words, %0d result words, across five limit/age settings",
                 words_in, words_out);
        $display("including zero, above-depth and full-range settings and three stall mixes");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
